// ----- hdl/dsg_pkg.sv -----
package dsg_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_REJECT_EXT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REJECT_MODE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CALL_TONE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LENIENT     = 3'd3;

	localparam logic [1:0] MODE_AWAIT = 2'd0;
	localparam logic [1:0] MODE_TONE  = 2'd1;
	localparam logic [1:0] MODE_PULSE = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	localparam logic [1:0] GRADE_FATAL     = 2'd0;
	localparam logic [1:0] GRADE_INVALID   = 2'd1;
	localparam logic [1:0] GRADE_TOLERABLE = 2'd2;
	localparam logic [1:0] GRADE_VALID     = 2'd3;

	localparam logic [7:0] POS_NONE       = 8'hFE;
	localparam logic [7:0] COUNT_MAX      = 8'hFF;
	localparam logic [7:0] CALL_TONE_NOCARET = 8'd2;
	localparam logic [7:0] CHAR_END       = 8'h00;

	typedef struct packed {
		logic       reject_extended_digits;
		logic       reject_mode_switch;
		logic [7:0] calling_tone_setting;
		logic       lenient_validation;
	} cfg_t;

	typedef struct packed {
		logic [7:0] count;
		logic [1:0] mode;
		logic [1:0] grade;
		logic [7:0] last_idx;
		logic       semi;
		logic       too_long;
	} str_state_t;

	typedef struct packed {
		logic [1:0] grade;
		logic [7:0] pos;
		logic       unusable;
	} result_t;

	localparam str_state_t STR_RESET = '{
		count:    8'd0,
		mode:     MODE_AWAIT,
		grade:    GRADE_VALID,
		last_idx: POS_NONE,
		semi:     1'b0,
		too_long: 1'b0
	};

	// Lowers a grade to the floor chosen by the leniency setting, never raises it.
	function automatic logic [1:0] lower_grade(input logic [1:0] g, input logic lenient);
		logic [1:0] floor_g;
		floor_g = lenient ? GRADE_TOLERABLE : GRADE_INVALID;
		return (g > floor_g) ? floor_g : g;
	endfunction

endpackage

// ----- hdl/dial_string_grader_top.sv -----
// Channel   Direction  Signals                                      Moves
// in        sink       in_valid, in_ready, dial_char, keep_position one byte request
// out       source     out_valid, out_ready, grade,                 one grade request
//                      last_dial_position, unusable
// cfg       sink       cfg_valid, cfg_ready, cfg_index, cfg_data    one register write
//
// A byte is taken into the input register and classified in the next cycle, so one
// byte is accepted every cycle unless an ending byte waits there. The ending zero byte
// loads the result register as it leaves the input register; its grade is offered there.
// While a result waits, bytes keep flowing until the next ending byte, which is held in
// the input register and stalls the input until the waiting result is taken.
// Reset clears the valid flags, configuration and string state; no clearing pass is needed.
module dial_string_grader_top #(
	parameter int MAX_DIAL_LENGTH = 127
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    dial_char,
	input  logic                          keep_position,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    grade,
	output logic signed [7:0]             last_dial_position,
	output logic                          unusable,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dsg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);

	dsg_pkg::cfg_t       cfg;
	dsg_pkg::str_state_t str_q;
	dsg_pkg::str_state_t str_nxt;
	dsg_pkg::result_t    res;
	dsg_pkg::result_t    res_q;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       keep_s1;
	logic       out_free;
	logic       go_s1;
	logic       is_end_s1;

	assign cfg_ready = 1'b1;

	dsg_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	dsg_step #(
		.MAX_DIAL_LENGTH (MAX_DIAL_LENGTH)
	) u_step (
		.cfg           (cfg),
		.cur           (str_q),
		.dial_char     (char_s1),
		.keep_position (keep_s1),
		.nxt           (str_nxt),
		.res           (res)
	);

	assign is_end_s1 = (char_s1 == dsg_pkg::CHAR_END);
	assign out_free  = !out_valid || out_ready;
	assign go_s1     = valid_s1 && (!is_end_s1 || out_free);
	assign in_ready  = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= dial_char;
			keep_s1 <= keep_position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			str_q <= dsg_pkg::STR_RESET;
		end else if (go_s1) begin
			str_q <= str_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (go_s1 && is_end_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && is_end_s1) begin
			res_q <= res;
		end
	end

	assign grade              = res_q.grade;
	assign last_dial_position = $signed(res_q.pos);
	assign unusable           = res_q.unusable;

endmodule

// ----- hdl/dsg_cfg_regs.sv -----
module dsg_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [dsg_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [7:0]                    wr_data,
	output dsg_pkg::cfg_t                 cfg
);

	dsg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				dsg_pkg::REG_REJECT_EXT:  cfg_q.reject_extended_digits <= wr_data[0];
				dsg_pkg::REG_REJECT_MODE: cfg_q.reject_mode_switch     <= wr_data[0];
				dsg_pkg::REG_CALL_TONE:   cfg_q.calling_tone_setting   <= wr_data;
				dsg_pkg::REG_LENIENT:     cfg_q.lenient_validation     <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/dsg_step.sv -----
module dsg_step #(
	parameter int MAX_DIAL_LENGTH = 127
) (
	input  dsg_pkg::cfg_t      cfg,
	input  dsg_pkg::str_state_t cur,
	input  logic [7:0]         dial_char,
	input  logic               keep_position,
	output dsg_pkg::str_state_t nxt,
	output dsg_pkg::result_t   res
);

	localparam logic [7:0] MaxLen = 8'(MAX_DIAL_LENGTH);

	logic       too_long_n;
	logic       illegal;
	logic       moded;
	logic [1:0] g;
	logic [1:0] end_grade;

	always_comb begin
		nxt        = cur;
		illegal    = 1'b0;
		g          = cur.grade;
		too_long_n = cur.too_long || (cur.count >= MaxLen);
		moded      = (cur.mode == dsg_pkg::MODE_TONE) || (cur.mode == dsg_pkg::MODE_PULSE);

		if (cur.too_long) begin
			end_grade = dsg_pkg::GRADE_FATAL;
		end else if (cur.mode == dsg_pkg::MODE_AWAIT) begin
			end_grade = dsg_pkg::GRADE_VALID;
		end else if (cur.mode == dsg_pkg::MODE_NONE) begin
			end_grade = dsg_pkg::GRADE_INVALID;
		end else begin
			end_grade = cur.grade;
		end
		res.grade    = end_grade;
		res.pos      = (keep_position && moded && !cur.too_long) ? cur.last_idx
		                                                          : dsg_pkg::POS_NONE;
		res.unusable = (end_grade <= dsg_pkg::GRADE_INVALID);

		if (dial_char == dsg_pkg::CHAR_END) begin
			nxt = dsg_pkg::STR_RESET;
		end else begin
			nxt.count    = (cur.count == dsg_pkg::COUNT_MAX) ? cur.count : cur.count + 8'd1;
			nxt.too_long = too_long_n;
			if (!too_long_n) begin
				unique case (cur.mode)
					dsg_pkg::MODE_AWAIT: begin
						if (dial_char == "T" || dial_char == "t") begin
							nxt.mode = dsg_pkg::MODE_TONE;
						end else if (dial_char == "P" || dial_char == "p") begin
							nxt.mode = dsg_pkg::MODE_PULSE;
						end else begin
							nxt.mode = dsg_pkg::MODE_NONE;
						end
					end
					dsg_pkg::MODE_NONE: ;
					default: begin
						// A semicolon followed by anything but the end of string is illegal.
						if (cur.semi) begin
							g = dsg_pkg::lower_grade(g, cfg.lenient_validation);
						end
						nxt.semi = 1'b0;
						case (dial_char) inside
							[8'h30:8'h39], "*", "#", "!": nxt.last_idx = cur.count;
							" ", "$", "(", ")", ",", "-", "@", 8'h57, "w": ;
							[8'h41:8'h44], [8'h61:8'h64]: begin
								if (cfg.reject_extended_digits) begin
									illegal = 1'b1;
								end else begin
									nxt.last_idx = cur.count;
								end
							end
							"T", "t": illegal = (cur.mode != dsg_pkg::MODE_TONE) &&
							                    cfg.reject_mode_switch;
							"P", "p": illegal = (cur.mode != dsg_pkg::MODE_PULSE) &&
							                    cfg.reject_mode_switch;
							"^": illegal = (cfg.calling_tone_setting == dsg_pkg::CALL_TONE_NOCARET);
							";": nxt.semi = 1'b1;
							default: illegal = 1'b1;
						endcase
						if (illegal) begin
							g = dsg_pkg::lower_grade(g, cfg.lenient_validation);
						end
						nxt.grade = g;
					end
				endcase
			end
		end
	end

endmodule

// ----- hdl/dsg_checker.sv -----
module dsg_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [1:0]                    grade,
	input logic signed [7:0]             last_dial_position,
	input logic                          unusable
);

	// The usable flag must agree with the grade it is reported with.
	a_unusable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (unusable == (grade <= dsg_pkg::GRADE_INVALID)))
		else $error("unusable disagrees with grade");

	// A fatal string never reports a dialable position.
	a_fatal_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && grade == dsg_pkg::GRADE_FATAL) |->
		(last_dial_position == $signed(dsg_pkg::POS_NONE)))
		else $error("fatal grade with a dial position");

	// With no result waiting, the input side can never be blocked.
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(grade) && $stable(last_dial_position) && $stable(unusable)))
		else $error("stalled result changed");

endmodule

bind dial_string_grader_top dsg_checker u_dsg_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_ready           (in_ready),
	.out_valid          (out_valid),
	.out_ready          (out_ready),
	.grade              (grade),
	.last_dial_position (last_dial_position),
	.unusable           (unusable)
);
